### sv/ssit_pkg.sv
// Shared types, request and status codes for the sorted set insertion table.
package ssit_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int KEY_W            = 32;
   localparam int POS_W            = 6;
   localparam int COUNT_W          = 7;
   localparam int STATUS_W         = 3;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_DUMP   = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ENTRY     = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd4;

   typedef struct packed {
      logic                    req_type;
      logic signed [KEY_W-1:0] key_in;
   } ssit_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [POS_W-1:0]        position;
      logic signed [KEY_W-1:0] key_out;
      logic [COUNT_W-1:0]      entry_count;
      logic                    last;
   } ssit_rsp_type;

   typedef enum logic [1:0] {
      DP_NOP,
      DP_INSERT,
      DP_DUMP_START,
      DP_DUMP_NEXT
   } ssit_op_type;

   typedef struct packed {
      ssit_op_type op;
   } ssit_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic first_last;
      logic next_last;
   } ssit_status_type;

   typedef enum logic {
      CTL_IDLE,
      CTL_DUMP
   } ssit_state_type;

endpackage

### sv/ssit_datapath.sv
// Key cell row with parallel compare and shift, dump rotation and result register.
module ssit_datapath
   import ssit_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  ssit_cmd_type    cmd,
   input  ssit_req_type    req_data,
   output ssit_status_type status,
   output ssit_rsp_type    rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic signed [KEY_W-1:0] cells_ff [CAPACITY];
   logic signed [KEY_W-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        idx_ff, idx_in;
   ssit_rsp_type            rsp_ff, rsp_in;

   logic [CAPACITY-1:0]     lt;
   logic [CAPACITY-1:0]     eq;
   logic [CAPACITY-1:0]     first;
   logic [IDX_W-1:0]        pos;
   logic [CNT_W-1:0]        count_m1;
   logic                    dup;
   logic                    full;

   assign count_m1 = count_ff - CNT_W'(1);
   assign full     = (count_ff == CNT_W'(CAPACITY));
   assign dup      = |eq;

   assign status.count_zero = (count_ff == '0);
   assign status.first_last = (count_ff == CNT_W'(1));
   assign status.next_last  = ((idx_ff + CNT_W'(1)) == count_ff);

   always_comb begin
      pos = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         lt[i] = (CNT_W'(i) < count_ff) && (cells_ff[i] < req_data.key_in);
         eq[i] = (CNT_W'(i) < count_ff) && (cells_ff[i] == req_data.key_in);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (i == 0) begin
            first[i] = !lt[i];
         end else begin
            first[i] = !lt[i] && lt[i-1];
         end
         if (first[i]) begin
            pos = pos | IDX_W'(i);
         end
      end
   end

   always_comb begin
      cells_in = cells_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      rsp_in   = rsp_ff;
      case (cmd.op)
         DP_INSERT: begin
            rsp_in.key_out     = req_data.key_in;
            rsp_in.last        = 1'b1;
            rsp_in.entry_count = COUNT_W'(count_ff);
            if (dup) begin
               rsp_in.status   = STATUS_DUPLICATE;
               rsp_in.position = POS_W'(pos);
            end else if (full) begin
               rsp_in.status   = STATUS_FULL;
               rsp_in.position = '0;
            end else begin
               rsp_in.status      = STATUS_INSERTED;
               rsp_in.position    = POS_W'(pos);
               rsp_in.entry_count = COUNT_W'(count_ff + CNT_W'(1));
               count_in           = count_ff + CNT_W'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (first[i]) begin
                     cells_in[i] = req_data.key_in;
                  end else if (i > 0 && !lt[i-1] && !first[i]) begin
                     cells_in[i] = cells_ff[i-1];
                  end
               end
            end
         end
         DP_DUMP_START, DP_DUMP_NEXT: begin
            if (status.count_zero) begin
               rsp_in.status      = STATUS_EMPTY;
               rsp_in.position    = '0;
               rsp_in.key_out     = '0;
               rsp_in.entry_count = '0;
               rsp_in.last        = 1'b1;
            end else begin
               rsp_in.status      = STATUS_ENTRY;
               rsp_in.key_out     = cells_ff[0];
               rsp_in.entry_count = COUNT_W'(count_ff);
               if (cmd.op == DP_DUMP_START) begin
                  rsp_in.position = '0;
                  rsp_in.last     = status.first_last;
                  idx_in          = CNT_W'(1);
               end else begin
                  rsp_in.position = POS_W'(idx_ff[IDX_W-1:0]);
                  rsp_in.last     = status.next_last;
                  idx_in          = idx_ff + CNT_W'(1);
               end
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_W'(i) == count_m1) begin
                     cells_in[i] = cells_ff[0];
                  end else if (i < CAPACITY - 1) begin
                     cells_in[i] = cells_ff[i+1];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      rsp_ff   <= rsp_in;
      idx_ff   <= idx_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### sv/ssit_controller.sv
// Request sequencing: accept control, dump walk and result valid tracking.
module ssit_controller
   import ssit_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_dump,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   input  ssit_status_type status,
   output ssit_cmd_type    cmd
);

   ssit_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = DP_NOP;
      req_stall = !((state_ff == CTL_IDLE) && out_free);
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid && out_free) begin
               if (req_dump == REQ_DUMP) begin
                  cmd.op = DP_DUMP_START;
                  if (!status.count_zero && !status.first_last) begin
                     state_in = CTL_DUMP;
                  end
               end else begin
                  cmd.op = DP_INSERT;
               end
            end
         end
         CTL_DUMP: begin
            if (out_free) begin
               cmd.op = DP_DUMP_NEXT;
               if (status.next_last) begin
                  state_in = CTL_IDLE;
               end
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
      rsp_valid_in = (cmd.op != DP_NOP) || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/sorted_set_insertion_table.sv
// Sorted set insertion table: top level joining controller and cell-row datapath.
//
// Keeps up to CAPACITY distinct signed 32-bit keys in ascending order.
// Request channel (req_valid/req_stall/req_data): req_type 0 inserts key_in,
// req_type 1 dumps the table. Result channel (rsp_valid/rsp_stall/rsp_data)
// carries status, position, key, entry count and a last flag.
// An insert compares the key against every cell at once and shifts larger
// keys up in the same cycle: one request per cycle while req_stall is low,
// one result, visible on the cycle after acceptance. A dump streams one
// stored key per cycle while rsp_stall is low, in ascending order by
// rotating the cell row, occupying the block until the last entry, which
// carries last = 1. An empty table dumps a single empty status.
// The result register frees as its result is taken, so a new request is
// accepted in the cycle the previous result leaves. While a pending result
// is held by rsp_stall, it stays unchanged and req_stall stays high.
// Reset (synchronous, active high) empties the table and drops any pending
// result; stored key cells are not cleared.
module sorted_set_insertion_table
   import ssit_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  ssit_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output ssit_rsp_type rsp_data
);

   ssit_cmd_type    cmd;
   ssit_status_type status;

   ssit_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_dump  (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ssit_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

### tb/sorted_set_insertion_table_tb.sv
// Self-checking testbench for the sorted set insertion table: shadow table predictor and tests.
module sorted_set_insertion_table_tb;
   import ssit_pkg::*;

   localparam int CAPACITY    = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   ssit_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   ssit_rsp_type rsp_data;

   logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
   int unsigned             shadow_count = 0;
   ssit_rsp_type            awaited_rsps [$];
   ssit_rsp_type            oldest_rsp;

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int hold_off_left  = 0;
   int error_count    = 0;
   int cycle_count    = 0;

   sorted_set_insertion_table #(.CAPACITY(CAPACITY)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side stall, with an optional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   function automatic void push_rsp(logic [STATUS_W-1:0] status, int unsigned pos,
                                    logic signed [KEY_W-1:0] key, int unsigned count,
                                    logic last);
      ssit_rsp_type r;
      r.status      = status;
      r.position    = POS_W'(pos);
      r.key_out     = key;
      r.entry_count = COUNT_W'(count);
      r.last        = last;
      awaited_rsps.push_back(r);
   endfunction

   function automatic void apply_to_shadow_table(ssit_req_type item);
      int unsigned slot;
      int unsigned i;
      if (item.req_type == REQ_DUMP) begin
         if (shadow_count == 0) begin
            push_rsp(STATUS_EMPTY, 0, '0, 0, 1'b1);
         end else begin
            for (i = 0; i < shadow_count; i++)
               push_rsp(STATUS_ENTRY, i, shadow_keys[i], shadow_count,
                        (i + 1 == shadow_count));
         end
      end else begin
         slot = 0;
         while (slot < shadow_count && shadow_keys[slot] < item.key_in) slot++;
         if (slot < shadow_count && shadow_keys[slot] == item.key_in) begin
            push_rsp(STATUS_DUPLICATE, slot, item.key_in, shadow_count, 1'b1);
         end else if (shadow_count >= CAPACITY) begin
            push_rsp(STATUS_FULL, 0, item.key_in, shadow_count, 1'b1);
         end else begin
            for (i = shadow_count; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[slot] = item.key_in;
            shadow_count++;
            push_rsp(STATUS_INSERTED, slot, item.key_in, shadow_count, 1'b1);
         end
      end
   endfunction

   function automatic bit key_is_stored(logic signed [KEY_W-1:0] key);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_keys[i] == key) return 1'b1;
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_rsps.size() == 0) begin
            $error("unexpected result: status %0d key %0d", rsp_data.status, rsp_data.key_out);
            error_count++;
         end else begin
            oldest_rsp = awaited_rsps.pop_front();
            if (rsp_data.status !== oldest_rsp.status) begin
               $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.position !== oldest_rsp.position) begin
               $error("position: expected %0d, actual %0d",
                      oldest_rsp.position, rsp_data.position);
               error_count++;
            end
            if (rsp_data.key_out !== oldest_rsp.key_out) begin
               $error("key_out: expected %0d, actual %0d", oldest_rsp.key_out, rsp_data.key_out);
               error_count++;
            end
            if (rsp_data.entry_count !== oldest_rsp.entry_count) begin
               $error("entry_count: expected %0d, actual %0d",
                      oldest_rsp.entry_count, rsp_data.entry_count);
               error_count++;
            end
            if (rsp_data.last !== oldest_rsp.last) begin
               $error("last: expected %0d, actual %0d", oldest_rsp.last, rsp_data.last);
               error_count++;
            end
         end
      end
   end

   task automatic send_request(input logic req_type, input logic signed [KEY_W-1:0] key);
      ssit_req_type item;
      item.req_type = req_type;
      item.key_in   = key;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_to_shadow_table(item);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_rsps.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) return KEY_W'($signed($urandom_range(32)) - 16);
      if (pick < 45) return {1'b1, {(KEY_W-3){1'b0}}, 2'($urandom_range(3))};
      if (pick < 50) return {1'b0, {(KEY_W-3){1'b1}}, 2'($urandom_range(3))};
      return $urandom();
   endfunction

   task automatic test_empty_dump();
      send_request(REQ_DUMP, $urandom());
      drain_results();
   endtask

   task automatic test_extreme_keys();
      send_request(REQ_INSERT, 0);
      send_request(REQ_INSERT, 32'sh7fffffff);
      send_request(REQ_INSERT, 32'sh80000000);
      send_request(REQ_INSERT, -1);
      send_request(REQ_INSERT, 1);
      send_request(REQ_INSERT, 32'sh55555555);
      send_request(REQ_INSERT, 32'shaaaaaaaa);
      send_request(REQ_DUMP, 32'shffffffff);
      drain_results();
   endtask

   task automatic test_duplicates();
      send_request(REQ_INSERT, 32'sh7fffffff);
      send_request(REQ_INSERT, 32'sh80000000);
      send_request(REQ_INSERT, 0);
      send_request(REQ_INSERT, 1);
      send_request(REQ_DUMP, 0);
      drain_results();
   endtask

   task automatic run_random_phase(int n_items, int req_pct, int rsp_pct);
      req_idle_pct  = req_pct;
      rsp_stall_pct = rsp_pct;
      repeat (n_items) begin
         if ($urandom_range(99) < 25) send_request(REQ_DUMP, $urandom());
         else                         send_request(REQ_INSERT, random_key());
      end
      drain_results();
   endtask

   task automatic test_random_traffic();
      run_random_phase(24, 0, 0);
      run_random_phase(24, 58, 0);
      run_random_phase(24, 0, 58);
      run_random_phase(24, 10, 10);
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
   endtask

   task automatic test_result_backpressure();
      hold_off_left = 300;
      repeat (12) begin
         if ($urandom_range(99) < 30) send_request(REQ_DUMP, $urandom());
         else                         send_request(REQ_INSERT, random_key());
      end
      drain_results();
   endtask

   task automatic test_full_table();
      logic signed [KEY_W-1:0] key;
      while (shadow_count < CAPACITY) send_request(REQ_INSERT, $urandom());
      do key = $urandom(); while (key_is_stored(key));
      send_request(REQ_INSERT, key);
      send_request(REQ_INSERT, shadow_keys[0]);
      send_request(REQ_INSERT, shadow_keys[CAPACITY-1]);
      send_request(REQ_DUMP, 0);
      rsp_stall_pct = 30;
      send_request(REQ_DUMP, 0);
      drain_results();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_dump();
      test_extreme_keys();
      test_duplicates();
      test_random_traffic();
      test_result_backpressure();
      test_full_table();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
